// File: hdl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types for the trial division primality tester
// ----------------------------------------------------------------------------
package ptd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam int unsigned FIRST_ODD_DIVISOR = 3;
    localparam int unsigned DIVISOR_STEP      = 2;

endpackage

// File: hdl/ptd_div.sv
// ----------------------------------------------------------------------------
// ptd_div
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptd_div #(
    parameter int W = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptd_pkg::t_div_ctl   i_ctl,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    output ptd_pkg::t_div_stat  o_stat,
    output logic [W-1:0]        o_remainder
);
    import ptd_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic [W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_dsr};
        if (diff[W]) begin
            n_rem = shifted[W-1:0];
        end else begin
            n_rem = diff[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

// File: hdl/primality_trial_division.sv
// ----------------------------------------------------------------------------
// primality_trial_division
// tests one unsigned number for primality by trial division with odd divisors
// decision: numbers up to 3 or even are decided without a division, else each
//   odd divisor up to sqrt(number) is tried in turn, up to sqrt(number) / 2 divisors
// throughput: one request at a time, the shared remainder unit sets the rate
// reset: synchronous active low, clears the sequencer and the remainder unit
// ----------------------------------------------------------------------------
module primality_trial_division #(
    parameter int NUMBER_BITS = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [NUMBER_BITS-1:0] i_number,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_is_prime
);
    import ptd_pkg::*;

    localparam int W = NUMBER_BITS;

    t_state        r_state;
    t_state        n_state;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_dsr;
    logic [W:0]    r_sq;
    logic          r_prime;

    t_div_ctl      div_ctl;
    t_div_stat     div_stat;
    logic [W-1:0]  div_rem;

    logic          accept;
    logic          sq_over;

    assign accept  = i_valid && o_ready;
    assign sq_over = r_sq > {1'b0, r_num};

    ptd_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_num),
        .i_divisor   (r_dsr),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_number < W'(2) || !i_number[0] || i_number == W'(3)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (sq_over) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        div_ctl.start = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready       = 1'b1;
            ST_DIV:   div_ctl.start = 1'b1;
            ST_DONE:  o_valid       = 1'b1;
            default:  ;
        endcase
    end

    assign o_is_prime = r_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_num   <= i_number;
                    r_dsr   <= W'(FIRST_ODD_DIVISOR);
                    r_sq    <= (W + 1)'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
                    if (i_number < W'(2)) begin
                        r_prime <= 1'b0;
                    end else if (!i_number[0]) begin
                        r_prime <= (i_number == W'(2));
                    end else begin
                        r_prime <= 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        r_prime <= 1'b0;
                    end else begin
                        r_dsr <= r_dsr + W'(DIVISOR_STEP);
                        r_sq  <= r_sq + (W + 1)'({r_dsr, 2'b00}) + (W + 1)'(4);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: tb/sv/primality_trial_division_checker.sv
// ----------------------------------------------------------------------------
// primality_trial_division_checker
// watches both channels of the primality tester, predicts the verdict of each
// accepted request by trial division and compares it with the returned result
// ----------------------------------------------------------------------------
module primality_trial_division_checker #(
    parameter int NUMBER_BITS = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [NUMBER_BITS-1:0] i_req_number,
    input  logic                   i_rsp_valid,
    input  logic                   i_rsp_ready,
    input  logic                   i_rsp_is_prime,
    output int                     o_fail_count,
    output int                     o_pending_count
);

    logic expected_verdicts[$];

    function automatic logic trial_division_verdict(input logic [NUMBER_BITS-1:0] number);
        longint unsigned value;
        longint unsigned divisor;
        value = number;
        if (value < 2)
            return 1'b0;
        if (value[0] == 1'b0)
            return (value == 2);
        for (divisor = 3; divisor * divisor <= value; divisor += 2) begin
            if (value % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        logic expected_prime;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                expected_verdicts = {expected_verdicts,
                                     trial_division_verdict(i_req_number)};
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("is_prime result with no request waiting: actual %0b",
                           i_rsp_is_prime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    expected_prime = expected_verdicts.pop_front();
                    if (i_rsp_is_prime !== expected_prime) begin
                        $error("is_prime mismatch: expected %0b actual %0b",
                               expected_prime, i_rsp_is_prime);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending_count <= expected_verdicts.size();
        end
    end

endmodule

// File: tb/sv/primality_trial_division_tb.sv
// ----------------------------------------------------------------------------
// primality_trial_division_tb
// drives numbers into the primality tester with random gaps and back-pressure,
// including a long receiver hold-off; the checker scores every verdict
// ----------------------------------------------------------------------------
module primality_trial_division_tb;

    localparam int NUMBER_BITS   = 17;
    localparam int RANDOM_COUNT  = 252;
    localparam int HOLD_CYCLES   = 3000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 6000000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [NUMBER_BITS-1:0] i_number;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_is_prime;

    int  fail_count;
    int  pending_count;
    int  cycle_count;
    int  results_seen;
    bit  no_gaps;

    primality_trial_division #(
        .NUMBER_BITS (NUMBER_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_prime (o_is_prime)
    );

    primality_trial_division_checker #(
        .NUMBER_BITS (NUMBER_BITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_number    (i_number),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_rsp_is_prime  (o_is_prime),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic offer_number(input logic [NUMBER_BITS-1:0] number);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= number;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    function automatic logic [NUMBER_BITS-1:0] random_number();
        int unsigned a;
        int unsigned b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return NUMBER_BITS'($urandom_range(0, (1 << NUMBER_BITS) - 1));
            4, 5:       return NUMBER_BITS'($urandom_range(0, (1 << NUMBER_BITS) - 1) | 1);
            6: begin
                a = $urandom_range(1, 180) * 2 + 1;
                b = $urandom_range(1, 180) * 2 + 1;
                return NUMBER_BITS'(a * b);
            end
            7: begin
                a = $urandom_range(1, 180) * 2 + 1;
                return NUMBER_BITS'(a * a);
            end
            default:    return NUMBER_BITS'($urandom_range(0, 64));
        endcase
    endfunction

    // receiver: random stalls, a gap-free stretch and one long hold-off
    initial begin : receiver
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_seen == 30)
                stall = HOLD_CYCLES;
            else if (results_seen >= 120 && results_seen < 170)
                stall = 0;
            else
                stall = $urandom_range(0, 16);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            results_seen++;
            @(negedge i_clk);
        end
    end

    initial begin : sender
        logic [NUMBER_BITS-1:0] directed[$];
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_number      = '0;
        no_gaps       = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero, one, two, small primes, odd squares, long-running odd composites,
        // values around 2^16 and at the top of the 17-bit range, all ones
        directed = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 65521, 65535, 65536,
                     65537, 126727, 130321, 131070, 131071, 99991, 65534};
        foreach (directed[k])
            offer_number(directed[k]);

        for (int k = 0; k < RANDOM_COUNT; k++) begin
            no_gaps = (k >= 150 && k < 190);
            offer_number(random_number());
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
